// ===== src/dwm_pkg.sv =====
// Package with shared payload types and constants for the distinct window marker detector.
`timescale 1ns / 1ps

package dwm_pkg;

    // Field widths fixed by the interface
    localparam int unsigned SYMBOL_FIELD_W = 8;
    localparam int unsigned POSITION_W     = 32;
    localparam int unsigned WLEN_W         = 9;

    // Defaults for the top-level parameters
    localparam int unsigned SYMBOL_WIDTH_DEF = 8;
    localparam int unsigned COUNT_WIDTH_DEF  = 32;

    // Window length after reset
    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET = 9'd14;

    typedef struct packed {
        logic [SYMBOL_FIELD_W-1:0] symbol;
        logic                      new_stream;
    } in_t;

    typedef struct packed {
        logic                  marker_found;
        logic [POSITION_W-1:0] position;
        logic                  already_done;
    } out_t;

endpackage

// ===== src/dwm_table.sv =====
// Last-seen position table: synchronous memory with per-entry valid bits and write forwarding.
`timescale 1ns / 1ps

module dwm_table #(
    parameter int unsigned SYMBOL_WIDTH = dwm_pkg::SYMBOL_WIDTH_DEF,
    parameter int unsigned COUNT_WIDTH  = dwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [SYMBOL_WIDTH-1:0] rd_addr,
    input  logic                    wr_en,
    input  logic [SYMBOL_WIDTH-1:0] wr_addr,
    input  logic [COUNT_WIDTH-1:0]  wr_data,
    output logic [COUNT_WIDTH-1:0]  rd_data
);

    localparam int unsigned DEPTH = 1 << SYMBOL_WIDTH;

    logic [COUNT_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]       vld_reg;
    logic [COUNT_WIDTH-1:0] mem_q_reg;
    logic                   vld_q_reg;
    logic                   hit_reg;
    logic [COUNT_WIDTH-1:0] byp_reg;

    // Write the entry and register the read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
            byp_reg   <= wr_data;
        end
    end

    // Mark entries written since reset; capture read-side flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg <= vld_reg[rd_addr];
                hit_reg   <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // Forward a write that lands on the same edge as the read; unwritten entries read zero
    always_comb
    begin
        if (hit_reg)
        begin
            rd_data = byp_reg;
        end
        else if (vld_q_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

// ===== src/dwm_track.sv =====
// Window tracker: stream counters, window start update and marker decision for one symbol.
`timescale 1ns / 1ps

module dwm_track #(
    parameter int unsigned SYMBOL_WIDTH = dwm_pkg::SYMBOL_WIDTH_DEF,
    parameter int unsigned COUNT_WIDTH  = dwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [SYMBOL_WIDTH-1:0]        sym,
    input  logic                           restart,
    input  logic [COUNT_WIDTH-1:0]         last_seen,
    input  logic [dwm_pkg::WLEN_W-1:0]     window_length,
    output logic                           wr_en,
    output logic [SYMBOL_WIDTH-1:0]        wr_addr,
    output logic [COUNT_WIDTH-1:0]         wr_data,
    output dwm_pkg::out_t                  result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam int unsigned PW = (COUNT_WIDTH > dwm_pkg::POSITION_W) ?
                                 COUNT_WIDTH : dwm_pkg::POSITION_W;
    localparam logic [PW-1:0] POS_CEIL = PW'({dwm_pkg::POSITION_W{1'b1}});

    logic [COUNT_WIDTH-1:0] gc_reg, gc_next;
    logic [COUNT_WIDTH-1:0] ws_reg, ws_next;
    logic [COUNT_WIDTH-1:0] base_reg, base_next;
    logic                   done_reg, done_next;

    logic                   sat;
    logic [COUNT_WIDTH-1:0] ws_r;
    logic                   done_r;
    logic [COUNT_WIDTH:0]   run_len;
    logic [COUNT_WIDTH:0]   need;
    logic                   found;
    logic [COUNT_WIDTH-1:0] pos_raw;
    logic [PW-1:0]          pos_ext;

    // Advance the stream state for one symbol
    always_comb
    begin
        sat    = (gc_reg == COUNT_MAX);
        ws_r   = restart ? (sat ? COUNT_MAX : gc_reg + 1'b1) : ws_reg;
        done_r = restart ? 1'b0 : done_reg;
        base_next = restart ? gc_reg : base_reg;

        // Window length zero acts as one
        need = (window_length == '0) ? (COUNT_WIDTH+1)'(1) : (COUNT_WIDTH+1)'(window_length);

        gc_next = sat ? gc_reg : gc_reg + 1'b1;
        ws_next = ws_r;
        if (!sat && (last_seen >= ws_r))
        begin
            ws_next = last_seen + 1'b1;
        end

        run_len = (COUNT_WIDTH+1)'(gc_next - ws_next) + 1'b1;
        found   = !sat && !done_r && (run_len >= need);
        done_next = done_r | found;

        // One-based position within the stream, floored at one and capped at 32 bits
        pos_raw = gc_next - base_next;
        if (pos_raw == '0)
        begin
            pos_raw = COUNT_WIDTH'(1);
        end
        pos_ext = PW'(pos_raw);
        if (pos_ext > POS_CEIL)
        begin
            pos_ext = POS_CEIL;
        end

        wr_en   = fire && !sat;
        wr_addr = sym;
        wr_data = gc_next;

        result.marker_found = found;
        result.position     = pos_ext[dwm_pkg::POSITION_W-1:0];
        result.already_done = done_r;
    end

    // Hold the stream state between transactions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gc_reg   <= '0;
            ws_reg   <= COUNT_WIDTH'(1);
            base_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (fire)
        begin
            gc_reg   <= gc_next;
            ws_reg   <= ws_next;
            base_reg <= base_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== src/distinct_window_marker_detector_top.sv =====
// Top level of the distinct window marker detector: handshake, pipeline registers, config.
`timescale 1ns / 1ps

// Takes one symbol per cycle and reports, once per stream, the first symbol at which the
// last window_length symbols are all different; every transaction yields one result with
// the symbol's one-based position in its stream. Sustained rate is one transaction per
// cycle while out_ready stays high. An accepted symbol is held in the compute stage
// register, and its result is registered in the output register that drives out_valid.
// The symbol reads its last-seen position from a table of 2^SYMBOL_WIDTH entries on the
// accept edge; the compute stage then computes the window update and writes the table
// back, with a write on the same edge as a read forwarded to that read. A stalled result
// holds the compute stage, which then holds off the input. The table needs no clearing
// pass after reset. window_length may be written only while the block is idle.

module distinct_window_marker_detector_top #(
    parameter int unsigned SYMBOL_WIDTH = dwm_pkg::SYMBOL_WIDTH_DEF,
    parameter int unsigned COUNT_WIDTH  = dwm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  dwm_pkg::in_t               in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output dwm_pkg::out_t              out_data,
    input  logic                       cfg_we,
    input  logic [dwm_pkg::WLEN_W-1:0] cfg_wdata
);

    logic [dwm_pkg::WLEN_W-1:0] wlen_reg;
    logic                       s1_valid_reg;
    dwm_pkg::in_t               s1_data_reg;
    logic                       out_valid_reg;
    dwm_pkg::out_t              out_data_reg;

    logic                       in_fire;
    logic                       s1_fire;
    logic [SYMBOL_WIDTH-1:0]    in_sym;
    logic [SYMBOL_WIDTH-1:0]    s1_sym;
    logic [COUNT_WIDTH-1:0]     last_seen;
    logic                       wr_en;
    logic [SYMBOL_WIDTH-1:0]    wr_addr;
    logic [COUNT_WIDTH-1:0]     wr_data;
    dwm_pkg::out_t              result;

    // Advance the compute stage when the output register is free or being drained
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    assign in_sym = SYMBOL_WIDTH'(in_data.symbol);
    assign s1_sym = SYMBOL_WIDTH'(s1_data_reg.symbol);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    dwm_table #(
        .SYMBOL_WIDTH (SYMBOL_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (in_sym),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (last_seen)
    );

    dwm_track #(
        .SYMBOL_WIDTH (SYMBOL_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (s1_fire),
        .sym           (s1_sym),
        .restart       (s1_data_reg.new_stream),
        .last_seen     (last_seen),
        .window_length (wlen_reg),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .result        (result)
    );

    // Hold the window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= dwm_pkg::WINDOW_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            wlen_reg <= cfg_wdata;
        end
    end

    // Track occupancy of the compute stage and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_fire)
        begin
            out_data_reg <= result;
        end
    end

endmodule
